### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tcrb_pkg.sv
// ----------------------------------------------------------------------------
// tcrb_pkg
// shared types and constants of the triggered capture ring buffer
// ----------------------------------------------------------------------------
package tcrb_pkg;

  localparam int WORD_W      = 32;
  localparam int CFG_W       = 13;
  localparam int PIN_W       = 5;
  localparam int IDX_W       = 2;

  localparam logic [CFG_W-1:0] DEPTH_RESET = 13'd4096;

  // request kinds on the input channel
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // configuration register map
  typedef enum logic [IDX_W-1:0] {
    REG_DEPTH    = 2'd0,
    REG_TRIG_EN  = 2'd1,
    REG_TRIG_PIN = 2'd2
  } cfg_reg_t;

  // store port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

### src/triggered_capture_ring_buffer.sv
// ----------------------------------------------------------------------------
// triggered_capture_ring_buffer
// logic-analyzer capture store with pin trigger and oldest-first dump
// ----------------------------------------------------------------------------
// Sample items write their 32-bit pin word into a ring of depth_in_use entries
// (saturated to 2..DEPTH) until capture freezes, either on a sample whose
// selected trigger pin is high while triggering is enabled, or on the first
// read item. Each read item returns one stored word, oldest first, starting at
// the write pointer; the newest word is flagged with last_word, and the dump
// then starts over. The block takes one item per clock cycle unless a read
// stalls because the read stage cannot move on; the word of a read passes
// through the input register, the registered read port of the store and the
// output register. A fill mark of how far the ring has ever been written makes
// entries never written read as zero, so there is no clearing pass after
// reset and the block is ready at once. Configuration is taken in any cycle
// (cfg_ready is always high) and must be written only while the block is idle.
module triggered_capture_ring_buffer #(
  parameter int DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcrb_pkg::IDX_W-1:0]        cfg_index,
  input  logic [tcrb_pkg::CFG_W-1:0]        cfg_wdata,
  // item input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [tcrb_pkg::WORD_W-1:0]       in_sample_word,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcrb_pkg::WORD_W-1:0]       out_read_word,
  output logic                              out_last_word,
  output logic                              out_was_triggered
);
  import tcrb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // ring address width
  localparam int CW = AW + 1;                           // count width, holds DEPTH
  localparam int XW = (CFG_W > CW) ? CFG_W : CW;        // width for depth clamp

  // configuration registers
  logic [CFG_W-1:0] depth_cfg_r;
  logic             trig_en_r;
  logic [PIN_W-1:0] trig_pin_r;

  // capture state
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [CW-1:0] fill_r, fill_nxt;          // entries [0, fill) have been written
  logic          capturing_r, capturing_nxt;
  logic          trig_seen_r, trig_seen_nxt;

  // input register
  logic              s1_valid_r;
  logic              s1_type_r;
  logic [WORD_W-1:0] s1_word_r;

  // read stage alongside the store's read register
  logic s2_valid_r;
  logic s2_last_r;
  logic s2_trig_r;
  logic s2_zero_r;

  // output register
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;
  logic              out_trig_r;

  // flow control
  logic o_free, s2_adv, s2_free, s1_adv;
  logic s1_is_read;

  // ring arithmetic
  logic [XW-1:0]     cfg_ext;
  logic [CW-1:0]     eff_depth;
  logic [AW-1:0]     wp_eff, off_eff;
  logic [CW-1:0]     wp_inc, off_inc;
  logic [CW-1:0]     idx_sum, idx_full;
  logic              rd_last, rd_zero, trig_hit;
  mem_ctrl_t         mem_ctrl;
  logic [WORD_W-1:0] rd_data;

  // ------------------------------------------------------------------------
  // handshakes: samples never wait on the output side, reads need the read
  // stage to be free or moving on
  // ------------------------------------------------------------------------
  assign cfg_ready  = 1'b1;
  assign s1_is_read = (s1_type_r == REQ_READ);
  assign o_free     = !out_valid_r || !out_stall;
  assign s2_adv     = s2_valid_r && o_free;
  assign s2_free    = !s2_valid_r || o_free;
  assign s1_adv     = s1_valid_r && (!s1_is_read || s2_free);
  assign in_stall   = s1_valid_r && !s1_adv;

  // ------------------------------------------------------------------------
  // configuration writes, out-of-map indexes are dropped
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_cfg_r <= DEPTH_RESET;
      trig_en_r   <= 1'b0;
      trig_pin_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEPTH:    depth_cfg_r <= cfg_wdata;
        REG_TRIG_EN:  trig_en_r   <= cfg_wdata[0];
        REG_TRIG_PIN: trig_pin_r  <= cfg_wdata[PIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // effective depth and pointers, out-of-range pointers fold to zero
  // ------------------------------------------------------------------------
  always_comb begin
    cfg_ext = XW'(depth_cfg_r);
    if (cfg_ext < XW'(2)) begin
      eff_depth = CW'(2);
    end else if (cfg_ext > XW'(DEPTH)) begin
      eff_depth = CW'(DEPTH);
    end else begin
      eff_depth = cfg_ext[CW-1:0];
    end
  end

  assign wp_eff  = ({1'b0, wp_r}  < eff_depth) ? wp_r  : '0;
  assign off_eff = ({1'b0, off_r} < eff_depth) ? off_r : '0;
  assign wp_inc  = {1'b0, wp_eff}  + CW'(1);
  assign off_inc = {1'b0, off_eff} + CW'(1);

  // read address is the oldest word plus the dump offset, modulo depth
  assign idx_sum  = {1'b0, wp_eff} + {1'b0, off_eff};
  assign idx_full = (idx_sum >= eff_depth) ? (idx_sum - eff_depth) : idx_sum;
  assign rd_last  = (off_inc == eff_depth);
  assign rd_zero  = (idx_full >= fill_r);   // never written since reset

  assign trig_hit = trig_en_r && s1_word_r[trig_pin_r];

  // ------------------------------------------------------------------------
  // state update for the item in the input register
  // ------------------------------------------------------------------------
  always_comb begin
    wp_nxt        = wp_r;
    off_nxt       = off_r;
    fill_nxt      = fill_r;
    capturing_nxt = capturing_r;
    trig_seen_nxt = trig_seen_r;
    mem_ctrl      = '0;
    if (s1_adv) begin
      if (!s1_is_read) begin
        // samples while frozen are dropped
        if (capturing_r) begin
          mem_ctrl.wr_en = 1'b1;
          wp_nxt = (wp_inc >= eff_depth) ? '0 : wp_inc[AW-1:0];
          if ({1'b0, wp_eff} >= fill_r) begin
            fill_nxt = wp_inc;
          end
          if (trig_hit) begin
            capturing_nxt = 1'b0;
            trig_seen_nxt = 1'b1;
          end
        end
      end else begin
        mem_ctrl.rd_en = 1'b1;
        capturing_nxt  = 1'b0;
        off_nxt        = rd_last ? '0 : off_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      off_r       <= '0;
      fill_r      <= '0;
      capturing_r <= 1'b1;
      trig_seen_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      off_r       <= off_nxt;
      fill_r      <= fill_nxt;
      capturing_r <= capturing_nxt;
      trig_seen_r <= trig_seen_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // input register
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_type_r <= in_req_type;
      s1_word_r <= in_sample_word;
    end
  end

  // ------------------------------------------------------------------------
  // sample store
  // ------------------------------------------------------------------------
  tcrb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctrl    (mem_ctrl),
    .wr_addr (wp_eff),
    .wr_data (s1_word_r),
    .rd_addr (idx_full[AW-1:0]),
    .rd_data (rd_data)
  );

  // ------------------------------------------------------------------------
  // read stage, runs beside the store's read register
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (mem_ctrl.rd_en) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctrl.rd_en) begin
      s2_last_r <= rd_last;
      s2_trig_r <= trig_seen_r;
      s2_zero_r <= rd_zero;
    end
  end

  // ------------------------------------------------------------------------
  // output register, holds while the far side stalls
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_word_r <= s2_zero_r ? '0 : rd_data;
      out_last_r <= s2_last_r;
      out_trig_r <= s2_trig_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_word     = out_word_r;
  assign out_last_word     = out_last_r;
  assign out_was_triggered = out_trig_r;

endmodule

### src/tcrb_store.sv
// ----------------------------------------------------------------------------
// tcrb_store
// sample word memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcrb_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  tcrb_pkg::mem_ctrl_t       ctrl,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tcrb_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [tcrb_pkg::WORD_W-1:0] rd_data
);
  import tcrb_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/tcrb_checker.sv
// ----------------------------------------------------------------------------
// tcrb_checker
// port-level checks of the capture ring buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcrb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_req_type,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [tcrb_pkg::WORD_W-1:0]       out_read_word,
  input logic                              out_last_word,
  input logic                              out_was_triggered
);
  import tcrb_pkg::*;

  logic       in_xfer, out_xfer, rd_xfer;
  logic [2:0] pending_r;     // reads taken but not yet delivered
  logic       trig_out_r;    // a delivered word has reported the trigger

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign rd_xfer  = in_xfer && (in_req_type == REQ_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      trig_out_r <= 1'b0;
    end else begin
      pending_r <= pending_r + {2'b00, rd_xfer} - {2'b00, out_xfer};
      if (out_xfer && out_was_triggered) begin
        trig_out_r <= 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_read_word) &&
      $stable(out_last_word) && $stable(out_was_triggered),
    "stalled result changed")
  `ASSERT_CLK(a_no_spurious, clk, rst_n, out_xfer |-> pending_r != 3'd0,
    "result without a pending read")
  `ASSERT_CLK(a_bounded, clk, rst_n, pending_r <= 3'd3,
    "more reads in flight than pipeline stages")
  `ASSERT_CLK(a_trig_sticky, clk, rst_n, out_xfer && trig_out_r |-> out_was_triggered,
    "trigger flag dropped after being reported")
  `ASSERT_CLK_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid,
    "result valid after reset")

endmodule

bind triggered_capture_ring_buffer tcrb_checker u_tcrb_checker (.*);
